>>> rtl/cws_pkg.sv
package cws_pkg;

  localparam int PixW          = 8;
  localparam int ProdW         = 2 * PixW;
  localparam int RemW          = ProdW + 1;
  localparam int DivW          = PixW + 1;
  localparam int QuotW         = PixW;
  localparam int BitsPerStage  = 2;
  localparam int DivStages     = QuotW / BitsPerStage;
  localparam int CfgIdxW       = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LOW  = 2'd0,
    REG_WINDOW_HIGH = 2'd1,
    REG_OUTPUT_LOW  = 2'd2,
    REG_OUTPUT_HIGH = 2'd3
  } reg_idx_e;

  // per-pixel info that rides alongside the divider
  typedef struct packed {
    logic            last;
    logic            bypass;
    logic [PixW-1:0] bypass_val;
    logic [PixW-1:0] out_low;
    logic            neg;
  } side_t;

endpackage

>>> rtl/cws_div.sv
module cws_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [cws_pkg::RemW-1:0]   dividend_i,
  input  logic [cws_pkg::DivW-1:0]   divisor_i,
  input  cws_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [cws_pkg::QuotW-1:0]  quot_o,
  output cws_pkg::side_t             side_o
);

  localparam int Stages = cws_pkg::DivStages;
  localparam int RemW   = cws_pkg::RemW;
  localparam int DivW   = cws_pkg::DivW;
  localparam int QuotW  = cws_pkg::QuotW;
  localparam int Bps    = cws_pkg::BitsPerStage;

  logic [Stages-1:0] vld_q;
  logic [RemW-1:0]   rem_q  [Stages];
  logic [DivW-1:0]   dvs_q  [Stages];
  logic [QuotW-1:0]  quot_q [Stages];
  cws_pkg::side_t    side_q [Stages];

  // restoring division, two quotient bits per stage, MSB first
  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic              vld_in;
    logic [RemW-1:0]   rem_in;
    logic [DivW-1:0]   dvs_in;
    logic [QuotW-1:0]  quot_in;
    cws_pkg::side_t    side_in;
    logic [RemW-1:0]   rem_d;
    logic [QuotW-1:0]  quot_d;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = dividend_i;
      assign dvs_in  = divisor_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign dvs_in  = dvs_q[s-1];
      assign quot_in = quot_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [RemW-1:0] sh;
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int j = 0; j < Bps; j++) begin
        sh = {{(RemW-DivW){1'b0}}, dvs_in} << (QuotW - 1 - s * Bps - j);
        if (rem_d >= sh) begin
          rem_d = rem_d - sh;
          quot_d[QuotW - 1 - s * Bps - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      dvs_q[s]  <= dvs_in;
      quot_q[s] <= quot_d;
      side_q[s] <= side_in;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign quot_o  = quot_q[Stages-1];
  assign side_o  = side_q[Stages-1];

endmodule

>>> rtl/contrast_window_stretch_top.sv
// Window/level contrast stretch, one 8-bit grey pixel per clock. A pixel is
// taken on every edge with start high; busy stays low, so the stream never
// waits. Each result shows on pixel_out_o/last_out_o for one cycle with
// out_valid_o high, in input order; the receiver cannot stall and must take
// it then. A pixel passes through three front stages (window compare, 8x8
// multiply, rounding offset), a four-stage restoring divider giving two
// quotient bits per stage, and the output register. The config port is
// always ready; a register write applies to pixels taken after it and should
// be made with the pipeline empty.
module contrast_window_stretch_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [cws_pkg::PixW-1:0]      pixel_in_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  output logic [cws_pkg::PixW-1:0]      pixel_out_o,
  output logic                          last_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cws_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cws_pkg::PixW-1:0]      cfg_data_i
);

  localparam int PixW  = cws_pkg::PixW;
  localparam int ProdW = cws_pkg::ProdW;
  localparam int RemW  = cws_pkg::RemW;
  localparam int DivW  = cws_pkg::DivW;
  localparam int QuotW = cws_pkg::QuotW;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // config registers
  logic [PixW-1:0] win_lo_q, win_hi_q, out_lo_q, out_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= '0;
      win_hi_q <= '1;
      out_lo_q <= '0;
      out_hi_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cws_pkg::reg_idx_e'(cfg_index_i))
        cws_pkg::REG_WINDOW_LOW:  win_lo_q <= cfg_data_i;
        cws_pkg::REG_WINDOW_HIGH: win_hi_q <= cfg_data_i;
        cws_pkg::REG_OUTPUT_LOW:  out_lo_q <= cfg_data_i;
        cws_pkg::REG_OUTPUT_HIGH: out_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: window compare, offsets
  logic            below, above, in_fire;
  cws_pkg::side_t  s1_side_d;
  logic [PixW-1:0] s1_diff_d, s1_mag_d, s1_span_d;

  assign in_fire = start && !busy;
  assign below   = (pixel_in_i <= win_lo_q);
  assign above   = (pixel_in_i >= win_hi_q);

  always_comb begin
    s1_side_d.last       = last_in_i;
    s1_side_d.bypass     = below || above;
    s1_side_d.bypass_val = below ? out_lo_q : out_hi_q;
    s1_side_d.out_low    = out_lo_q;
    s1_side_d.neg        = (out_hi_q < out_lo_q);
    s1_mag_d  = s1_side_d.neg ? (out_lo_q - out_hi_q) : (out_hi_q - out_lo_q);
    s1_diff_d = pixel_in_i - win_lo_q;
    s1_span_d = win_hi_q - win_lo_q;
  end

  logic            s1_vld_q, s2_vld_q, s3_vld_q;
  cws_pkg::side_t  s1_side_q, s2_side_q, s3_side_q;
  logic [PixW-1:0] s1_diff_q, s1_mag_q, s1_span_q, s2_span_q;
  logic [ProdW-1:0] s2_prod_q;
  logic [RemW-1:0] s3_dvd_q;
  logic [DivW-1:0] s3_dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_fire;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= s1_side_d;
    s1_diff_q <= s1_diff_d;
    s1_mag_q  <= s1_mag_d;
    s1_span_q <= s1_span_d;
    // stage 2: product
    s2_side_q <= s1_side_q;
    s2_prod_q <= s1_diff_q * s1_mag_q;
    s2_span_q <= s1_span_q;
    // stage 3: rounded dividend 2*num + span over 2*span
    s3_side_q <= s2_side_q;
    s3_dvd_q  <= {s2_prod_q, 1'b0} + {{(RemW-PixW){1'b0}}, s2_span_q};
    s3_dvs_q  <= {s2_span_q, 1'b0};
  end

  logic            dv_vld;
  logic [QuotW-1:0] dv_quot;
  cws_pkg::side_t  dv_side;

  cws_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s3_vld_q),
    .dividend_i (s3_dvd_q),
    .divisor_i  (s3_dvs_q),
    .side_i     (s3_side_q),
    .valid_o    (dv_vld),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  // output stage
  logic            out_vld_q, last_q;
  logic [PixW-1:0] pix_d, pix_q;

  always_comb begin
    if (dv_side.bypass) begin
      pix_d = dv_side.bypass_val;
    end else if (dv_side.neg) begin
      pix_d = dv_side.out_low - dv_quot;
    end else begin
      pix_d = dv_side.out_low + dv_quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    last_q <= dv_side.last;
  end

  assign out_valid_o = out_vld_q;
  assign pixel_out_o = pix_q;
  assign last_out_o  = last_q;

endmodule

>>> sim/tb_contrast_window_stretch_top.sv
`timescale 1ns / 100ps

module tb_contrast_window_stretch_top;

  localparam int NumRows     = 42;
  localparam int NumPhases   = 14;
  localparam int PhaseItems  = 50;
  localparam int DrainCycles = 12;

  typedef enum logic {
    ROW_CFG,
    ROW_PIX
  } row_kind_e;

  // val is the register data for ROW_CFG and the input pixel for ROW_PIX
  typedef struct packed {
    row_kind_e                 kind;
    cws_pkg::reg_idx_e         idx;
    logic [cws_pkg::PixW-1:0]  val;
    logic                      last;
    logic                      typed;
    logic [cws_pkg::PixW-1:0]  want;
  } row_t;

  typedef struct packed {
    logic [cws_pkg::PixW-1:0] pixel;
    logic                     last;
  } stretched_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start       = 1'b0;
  logic                         busy;
  logic [cws_pkg::PixW-1:0]     pixel_in_i  = '0;
  logic                         last_in_i   = 1'b0;
  logic                         out_valid_o;
  logic [cws_pkg::PixW-1:0]     pixel_out_o;
  logic                         last_out_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [cws_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [cws_pkg::PixW-1:0]     cfg_data_i  = '0;

  // shadow copy of the window / level registers
  logic [cws_pkg::PixW-1:0] win_lo = 8'd0;
  logic [cws_pkg::PixW-1:0] win_hi = 8'd255;
  logic [cws_pkg::PixW-1:0] lvl_lo = 8'd0;
  logic [cws_pkg::PixW-1:0] lvl_hi = 8'd255;

  stretched_t expected_pixels [$];
  stretched_t oldest;
  int         mismatches = 0;

  row_t directed_rows [NumRows] = '{
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd0,   1'b0, 1'b1, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd255, 1'b1, 1'b1, 8'd255},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd128, 1'b0, 1'b1, 8'd128},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'h55,  1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_WINDOW_LOW,  8'd50,  1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_WINDOW_HIGH, 8'd200, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_LOW,  8'd10,  1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_HIGH, 8'd240, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd50,  1'b0, 1'b1, 8'd10},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd49,  1'b0, 1'b1, 8'd10},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd200, 1'b0, 1'b1, 8'd240},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd255, 1'b1, 1'b1, 8'd240},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd51,  1'b0, 1'b0, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd199, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'haa,  1'b1, 1'b0, 8'd0},
    // window 0..2 onto 0..1: pixel 1 sits on an exact half
    '{ROW_CFG, cws_pkg::REG_WINDOW_LOW,  8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_WINDOW_HIGH, 8'd2,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_LOW,  8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_HIGH, 8'd1,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd1,   1'b0, 1'b0, 8'd0},
    // same half with the output levels swapped
    '{ROW_CFG, cws_pkg::REG_OUTPUT_LOW,  8'd1,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_HIGH, 8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd1,   1'b0, 1'b0, 8'd0},
    // inverted window
    '{ROW_CFG, cws_pkg::REG_WINDOW_LOW,  8'd200, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_WINDOW_HIGH, 8'd100, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_LOW,  8'd7,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_HIGH, 8'd250, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd150, 1'b0, 1'b1, 8'd7},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd200, 1'b0, 1'b1, 8'd7},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd201, 1'b0, 1'b1, 8'd250},
    // empty window
    '{ROW_CFG, cws_pkg::REG_WINDOW_LOW,  8'd100, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_WINDOW_HIGH, 8'd100, 1'b0, 1'b0, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd100, 1'b0, 1'b1, 8'd7},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd101, 1'b0, 1'b1, 8'd250},
    // full window, inverted output range
    '{ROW_CFG, cws_pkg::REG_WINDOW_LOW,  8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_WINDOW_HIGH, 8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_LOW,  8'd255, 1'b0, 1'b0, 8'd0},
    '{ROW_CFG, cws_pkg::REG_OUTPUT_HIGH, 8'd0,   1'b0, 1'b0, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd100, 1'b0, 1'b1, 8'd155},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd0,   1'b0, 1'b1, 8'd255},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd255, 1'b1, 1'b1, 8'd0},
    '{ROW_PIX, cws_pkg::REG_WINDOW_LOW,  8'd254, 1'b0, 1'b0, 8'd0}
  };

  contrast_window_stretch_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .pixel_in_i  (pixel_in_i),
    .last_in_i   (last_in_i),
    .out_valid_o (out_valid_o),
    .pixel_out_o (pixel_out_o),
    .last_out_o  (last_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // linear stretch with round half away from the low output level
  function automatic logic [cws_pkg::PixW-1:0] stretched_level(
      logic [cws_pkg::PixW-1:0] px);
    int unsigned span;
    int unsigned mag;
    int unsigned num;
    int unsigned q;
    if (px <= win_lo) return lvl_lo;
    if (px >= win_hi) return lvl_hi;
    span = int'(win_hi) - int'(win_lo);
    mag  = (lvl_hi >= lvl_lo) ? int'(lvl_hi) - int'(lvl_lo) : int'(lvl_lo) - int'(lvl_hi);
    num  = (int'(px) - int'(win_lo)) * mag;
    q    = (2 * num + span) / (2 * span);
    if (lvl_hi >= lvl_lo) return cws_pkg::PixW'(int'(lvl_lo) + q);
    return cws_pkg::PixW'(int'(lvl_lo) - q);
  endfunction

  function automatic logic [cws_pkg::PixW-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  // start is left high after the beat so back-to-back pixels keep it up
  task automatic send_pixel(logic [cws_pkg::PixW-1:0] px, logic last,
                            logic [cws_pkg::PixW-1:0] want, int gap);
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    pixel_in_i <= px;
    last_in_i  <= last;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_pixels.push_back('{pixel: want, last: last});
  endtask

  // only with the pipeline empty
  task automatic write_reg(cws_pkg::reg_idx_e idx, logic [cws_pkg::PixW-1:0] val);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      cws_pkg::REG_WINDOW_LOW:  win_lo = val;
      cws_pkg::REG_WINDOW_HIGH: win_hi = val;
      cws_pkg::REG_OUTPUT_LOW:  lvl_lo = val;
      cws_pkg::REG_OUTPUT_HIGH: lvl_hi = val;
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected beat, pixel", int'(pixel_out_o), 0);
      end else begin
        oldest = expected_pixels.pop_front();
        if (pixel_out_o !== oldest.pixel)
          report_mismatch("pixel_out", int'(pixel_out_o), int'(oldest.pixel));
        if (last_out_o !== oldest.last)
          report_mismatch("last_out", int'(last_out_o), int'(oldest.last));
      end
    end
  end

  initial begin
    logic [cws_pkg::PixW-1:0] px;
    logic [cws_pkg::PixW-1:0] lo;
    logic [cws_pkg::PixW-1:0] hi;
    logic [cws_pkg::PixW-1:0] tmp;
    logic                     last;
    logic                     burst;
    int                       gap;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_pixel(directed_rows[i].val, directed_rows[i].last,
                   directed_rows[i].typed ? directed_rows[i].want
                                          : stretched_level(directed_rows[i].val),
                   $urandom_range(0, 11));
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      lo = pick_level();
      hi = pick_level();
      if (ph == 0) begin
        lo = 8'd255;
        hi = 8'd0;
      end else if ($urandom_range(0, 3) != 0 && lo >= hi) begin
        // mostly keep a proper window so the divider path gets exercised
        if (lo == hi) begin
          if (hi != 8'd255) hi = hi + 8'd1;
          else lo = lo - 8'd1;
        end else begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end
      write_reg(cws_pkg::REG_WINDOW_LOW, lo);
      write_reg(cws_pkg::REG_WINDOW_HIGH, hi);
      write_reg(cws_pkg::REG_OUTPUT_LOW, pick_level());
      write_reg(cws_pkg::REG_OUTPUT_HIGH, pick_level());
      burst = ($urandom_range(0, 3) == 0);

      for (int k = 0; k < PhaseItems; k++) begin
        if (ph == 3 && k == PhaseItems / 2) begin
          start <= 1'b0;
          while (expected_pixels.size() != 0) @(posedge clk_i);
        end
        case ($urandom_range(0, 7))
          0:       px = win_lo + 8'($urandom_range(0, 2)) - 8'd1;
          1:       px = win_hi + 8'($urandom_range(0, 2)) - 8'd1;
          default: px = 8'($urandom_range(0, 255));
        endcase
        last = ($urandom_range(0, 15) == 0);
        gap  = burst ? 0 : $urandom_range(0, 11);
        send_pixel(px, last, stretched_level(px), gap);
      end
    end

    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
